FILE: hw/rtl/s_expression_char_lexer_top_defines.svh
// ----------------------------------------------------------------------------
// s-expression lexer assertion macros
// shared property shorthands for the lexer rtl
// ----------------------------------------------------------------------------
`ifndef S_EXPRESSION_CHAR_LEXER_TOP_DEFINES_SVH
`define S_EXPRESSION_CHAR_LEXER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SXL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SXL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sexp_lex_pkg.sv
// ----------------------------------------------------------------------------
// s-expression lexer package
// word types, token kind and error codes, lexer modes and character constants
// ----------------------------------------------------------------------------
package sexp_lex_pkg;

    localparam int unsigned C_POS_WIDTH = 16;
    localparam int unsigned C_Q_DEPTH   = 4;
    localparam int unsigned C_Q_PTR_W   = $clog2(C_Q_DEPTH);

    // token kinds
    localparam logic [2:0] K_NUMBER  = 3'd0;
    localparam logic [2:0] K_SYMBOL  = 3'd1;
    localparam logic [2:0] K_LPAREN  = 3'd2;
    localparam logic [2:0] K_RPAREN  = 3'd3;
    localparam logic [2:0] K_BINDING = 3'd4;
    localparam logic [2:0] K_END     = 3'd5;
    localparam logic [2:0] K_ERROR   = 3'd6;

    // error codes
    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_NO_FRAC    = 2'd1;
    localparam logic [1:0] E_EMPTY_BIND = 2'd2;
    localparam logic [1:0] E_UNEXPECTED = 2'd3;

    // characters
    localparam logic [7:0] C_CH_DOLLAR = 8'h24;
    localparam logic [7:0] C_CH_LPAREN = 8'h28;
    localparam logic [7:0] C_CH_RPAREN = 8'h29;
    localparam logic [7:0] C_CH_DOT    = 8'h2E;
    localparam logic [7:0] C_CH_MINUS  = 8'h2D;
    localparam logic [7:0] C_CH_LF     = 8'h0A;
    localparam logic [7:0] C_CH_UNDER  = 8'h5F;
    localparam logic [7:0] C_CH_NUL    = 8'h00;

    typedef enum logic [8:0] {
        M_START      = 9'b000000001,
        M_NUM_INT    = 9'b000000010,
        M_NUM_POINT  = 9'b000000100,
        M_NUM_FRAC   = 9'b000001000,
        M_SYMBOL     = 9'b000010000,
        M_BIND_SIGIL = 9'b000100000,
        M_BIND_NAME  = 9'b001000000,
        M_MINUS      = 9'b010000000,
        M_ERROR      = 9'b100000000
    } t_lex_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
    } t_lex_in;

    typedef struct packed {
        logic [7:0]             char_out;
        logic [2:0]             kind;
        logic                   starts_token;
        logic                   in_value;
        logic [C_POS_WIDTH-1:0] line_no;
        logic [C_POS_WIDTH-1:0] column_no;
        logic [1:0]             error_code;
        logic                   last_of_run;
    } t_lex_out;

endpackage

FILE: hw/rtl/s_expression_char_lexer_top.sv
// ----------------------------------------------------------------------------
// s-expression character lexer
// classifies a byte stream into number, symbol, paren, binding and end tokens
// ----------------------------------------------------------------------------
// A new source word is taken on every cycle in which the result queue has room
// for two result words, so the input side runs at one word per clock. Each
// input word yields zero, one or two result words; the output side delivers
// one result word per unstalled clock from a four-entry queue, so the sustained
// rate is one input word per cycle whenever every word makes at most one result
// and the receiver does not stall, and the output port sets the pace on runs of
// two-result words (a held '-' that is resolved, or end of source after a held
// '-'). The whole lexing step for a word is one pass of mode decode and position
// increment between the state registers and the queue; there is no clearing
// pass after reset. Results are registered into the queue and leave in order.
// ----------------------------------------------------------------------------
`include "s_expression_char_lexer_top_defines.svh"

module s_expression_char_lexer_top import sexp_lex_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // source word channel
    input  logic     i_in_valid,
    input  t_lex_in  i_in_word,
    output logic     o_in_stall,
    // result word channel
    output logic     o_out_valid,
    output t_lex_out o_out_word,
    input  logic     i_out_stall
);

    localparam logic [C_POS_WIDTH-1:0] POS_MAX = {C_POS_WIDTH{1'b1}};
    localparam logic [C_POS_WIDTH-1:0] POS_ONE = C_POS_WIDTH'(1);

    // lexer state
    t_lex_mode              r_mode, n_mode;
    logic [C_POS_WIDTH-1:0] r_line, n_line;
    logic [C_POS_WIDTH-1:0] r_col, n_col;
    logic [C_POS_WIDTH-1:0] r_held_line, n_held_line;
    logic [C_POS_WIDTH-1:0] r_held_col, n_held_col;

    // result queue
    t_lex_out               r_q [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0]   r_wr, r_rd;
    logic [C_Q_PTR_W:0]     r_count, n_count;

    // step logic
    t_lex_mode              eff_mode;
    t_lex_out               pre_res, main_res, slot0, slot1;
    logic                   pre_vld, main_vld, done;
    logic [1:0]             n_res;
    logic                   in_acc, out_acc;
    logic [7:0]             c;
    logic                   c_digit, c_name, c_sym, c_space;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic logic f_is_digit(input logic [7:0] ch);
        return (ch >= 8'h30) && (ch <= 8'h39);
    endfunction

    function automatic logic f_is_alnum(input logic [7:0] ch);
        return f_is_digit(ch) || ((ch >= 8'h61) && (ch <= 8'h7A))
            || ((ch >= 8'h41) && (ch <= 8'h5A));
    endfunction

    function automatic t_lex_out f_res(
        input logic [7:0]             ch,
        input logic [2:0]             kind,
        input logic                   st,
        input logic                   iv,
        input logic [C_POS_WIDTH-1:0] ln,
        input logic [C_POS_WIDTH-1:0] col,
        input logic [1:0]             err
    );
        t_lex_out r;
        r.char_out     = ch;
        r.kind         = kind;
        r.starts_token = st;
        r.in_value     = iv;
        r.line_no      = ln;
        r.column_no    = col;
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    assign c       = i_in_word.ch;
    assign c_digit = f_is_digit(c);
    assign c_name  = f_is_alnum(c) || (c == C_CH_UNDER);
    // '+', '*', '/' are symbol characters besides alnum, '-' and '_'
    assign c_sym   = c_name || (c == C_CH_MINUS) || (c == 8'h2B) || (c == 8'h2A)
                   || (c == 8'h2F);
    assign c_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == C_CH_LF);

    // ------------------------------------------------------------------------
    // handshakes: take a word only when two queue slots are free
    // ------------------------------------------------------------------------
    assign o_in_stall  = (r_count > (C_Q_PTR_W+1)'(C_Q_DEPTH - 2));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_out_word  = r_q[r_rd];

    // ------------------------------------------------------------------------
    // lexing step
    // a held '-' gives a leading result (pre), the byte itself at most one
    // more (main); the held minus resolves into number-int or symbol mode
    // before the byte is lexed in that mode
    // ------------------------------------------------------------------------
    always_comb begin
        pre_res     = '0;
        main_res    = '0;
        pre_vld     = 1'b0;
        main_vld    = 1'b0;
        done        = 1'b0;
        eff_mode    = r_mode;
        n_mode      = r_mode;
        n_line      = r_line;
        n_col       = r_col;
        n_held_line = r_held_line;
        n_held_col  = r_held_col;

        if (i_in_word.is_end) begin
            // end of source: flush pending state, then back to line 1 column 1
            unique case (r_mode)
                M_ERROR: begin
                end
                M_NUM_POINT: begin
                    main_vld = 1'b1;
                    main_res = f_res(C_CH_NUL, K_ERROR, 1'b0, 1'b0, r_line, r_col,
                                     E_NO_FRAC);
                end
                M_BIND_SIGIL: begin
                    main_vld = 1'b1;
                    main_res = f_res(C_CH_NUL, K_ERROR, 1'b0, 1'b0, r_line, r_col,
                                     E_EMPTY_BIND);
                end
                M_MINUS: begin
                    pre_vld  = 1'b1;
                    pre_res  = f_res(C_CH_MINUS, K_SYMBOL, 1'b1, 1'b1, r_held_line,
                                     r_held_col, E_NONE);
                    main_vld = 1'b1;
                    main_res = f_res(C_CH_NUL, K_END, 1'b1, 1'b0, r_line, r_col, E_NONE);
                end
                default: begin
                    main_vld = 1'b1;
                    main_res = f_res(C_CH_NUL, K_END, 1'b1, 1'b0, r_line, r_col, E_NONE);
                end
            endcase
            n_mode = M_START;
            n_line = POS_ONE;
            n_col  = POS_ONE;
        end else begin
            if (r_mode == M_MINUS) begin
                pre_vld  = 1'b1;
                pre_res  = f_res(C_CH_MINUS, c_digit ? K_NUMBER : K_SYMBOL, 1'b1, 1'b1,
                                 r_held_line, r_held_col, E_NONE);
                eff_mode = c_digit ? M_NUM_INT : M_SYMBOL;
            end
            n_mode = eff_mode;

            // continue the current token if the byte fits it
            unique case (eff_mode)
                M_ERROR: begin
                    done = 1'b1;
                end
                M_NUM_INT: begin
                    if (c_digit || (c == C_CH_DOT)) begin
                        main_vld = 1'b1;
                        main_res = f_res(c, K_NUMBER, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        done     = 1'b1;
                        if (c == C_CH_DOT) begin
                            n_mode = M_NUM_POINT;
                        end
                    end
                end
                M_NUM_POINT: begin
                    main_vld = 1'b1;
                    done     = 1'b1;
                    if (c_digit) begin
                        main_res = f_res(c, K_NUMBER, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        n_mode   = M_NUM_FRAC;
                    end else begin
                        main_res = f_res(c, K_ERROR, 1'b0, 1'b0, r_line, r_col, E_NO_FRAC);
                        n_mode   = M_ERROR;
                    end
                end
                M_NUM_FRAC: begin
                    if (c_digit) begin
                        main_vld = 1'b1;
                        main_res = f_res(c, K_NUMBER, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        done     = 1'b1;
                    end
                end
                M_SYMBOL: begin
                    if (c_sym) begin
                        main_vld = 1'b1;
                        main_res = f_res(c, K_SYMBOL, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        done     = 1'b1;
                    end
                end
                M_BIND_SIGIL: begin
                    main_vld = 1'b1;
                    done     = 1'b1;
                    if (c_name) begin
                        main_res = f_res(c, K_BINDING, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        n_mode   = M_BIND_NAME;
                    end else begin
                        main_res = f_res(c, K_ERROR, 1'b0, 1'b0, r_line, r_col,
                                         E_EMPTY_BIND);
                        n_mode   = M_ERROR;
                    end
                end
                M_BIND_NAME: begin
                    if (c_name) begin
                        main_vld = 1'b1;
                        main_res = f_res(c, K_BINDING, 1'b0, 1'b1, r_line, r_col, E_NONE);
                        done     = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // otherwise lex the byte afresh
            if (!done) begin
                if (c_space) begin
                    n_mode = M_START;
                end else if (c == C_CH_LPAREN) begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_LPAREN, 1'b1, 1'b1, r_line, r_col, E_NONE);
                    n_mode   = M_START;
                end else if (c == C_CH_RPAREN) begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_RPAREN, 1'b1, 1'b1, r_line, r_col, E_NONE);
                    n_mode   = M_START;
                end else if (c == C_CH_DOLLAR) begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_BINDING, 1'b1, 1'b0, r_line, r_col, E_NONE);
                    n_mode   = M_BIND_SIGIL;
                end else if (c_digit) begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_NUMBER, 1'b1, 1'b1, r_line, r_col, E_NONE);
                    n_mode   = M_NUM_INT;
                end else if (c == C_CH_MINUS) begin
                    // hold the minus and its position until the next byte
                    n_held_line = r_line;
                    n_held_col  = r_col;
                    n_mode      = M_MINUS;
                end else if (c_sym) begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_SYMBOL, 1'b1, 1'b1, r_line, r_col, E_NONE);
                    n_mode   = M_SYMBOL;
                end else begin
                    main_vld = 1'b1;
                    main_res = f_res(c, K_ERROR, 1'b0, 1'b0, r_line, r_col, E_UNEXPECTED);
                    n_mode   = M_ERROR;
                end
            end

            // saturating position update
            if (c == C_CH_LF) begin
                if (r_line != POS_MAX) begin
                    n_line = r_line + POS_ONE;
                end
                n_col = POS_ONE;
            end else if (r_col != POS_MAX) begin
                n_col = r_col + POS_ONE;
            end
        end
    end

    // pack results into consecutive queue slots, flag the last one
    always_comb begin
        n_res             = {1'b0, pre_vld} + {1'b0, main_vld};
        slot0             = pre_vld ? pre_res : main_res;
        slot0.last_of_run = (n_res == 2'd1);
        slot1             = main_res;
        slot1.last_of_run = 1'b1;
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + (C_Q_PTR_W+1)'(n_res);
        end
        if (out_acc) begin
            n_count = n_count - (C_Q_PTR_W+1)'(1);
        end
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_START;
            r_line      <= POS_ONE;
            r_col       <= POS_ONE;
            r_held_line <= '0;
            r_held_col  <= '0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
        end else begin
            if (in_acc) begin
                r_mode      <= n_mode;
                r_line      <= n_line;
                r_col       <= n_col;
                r_held_line <= n_held_line;
                r_held_col  <= n_held_col;
                r_wr        <= r_wr + C_Q_PTR_W'(n_res);
            end
            if (out_acc) begin
                r_rd <= r_rd + C_Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // queue storage, payload only
    always_ff @(posedge i_clk) begin
        if (in_acc && (n_res != 2'd0)) begin
            r_q[r_wr] <= slot0;
        end
        if (in_acc && (n_res == 2'd2)) begin
            r_q[r_wr + C_Q_PTR_W'(1)] <= slot1;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SXL_ASSERT_NOW(a_halt_silent, i_clk, i_rst_n, in_acc && (r_mode == M_ERROR) && !i_in_word.is_end, n_res == 2'd0, "byte after error produced a result")
    `SXL_ASSERT_NEXT(a_end_resets_pos, i_clk, i_rst_n, in_acc && i_in_word.is_end, (r_line == POS_ONE) && (r_col == POS_ONE) && (r_mode == M_START), "end of source did not restart position")
    `SXL_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, out_acc && !in_acc, r_count == ($past(r_count) - (C_Q_PTR_W+1)'(1)), "queue count wrong after pop")
    `SXL_ASSERT_NOW(a_err_code, i_clk, i_rst_n, o_out_valid && (o_out_word.kind == K_ERROR), o_out_word.error_code != E_NONE, "error word without error code")

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// s-expression character lexer testbench
// streams source words through the lexer under random idling and stalls, and
// checks every result word field by field against a lexer tracked in the
// testbench: directed corner cases and random token programs
// ----------------------------------------------------------------------------
module tb_top import sexp_lex_pkg::*; ();

    // run shape
    localparam int unsigned RANDOM_ITEMS = 1870;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 50;
    // long receiver hold-offs, in receiver cycles
    localparam int unsigned HOLD_AT_1    = 400;
    localparam int unsigned HOLD_AT_2    = 1500;
    localparam int unsigned HOLD_LEN     = 300;

    localparam logic [C_POS_WIDTH-1:0] POS_MAX = '1;
    localparam logic [C_POS_WIDTH-1:0] POS_ONE = C_POS_WIDTH'(1);

    // bytes not in the package
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // character sets for the stimulus generator
    localparam string DIGITS    = "0123456789";
    localparam string SYM_HEAD  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+*/_";
    localparam string SYM_BODY  = "abcxyzQRZ0123456789+-*/_";
    localparam string NAME_BODY = "abcdefxyzABCXYZ0123456789_";
    localparam string NO_FRAC   = "aZ_()$+-*/.";
    localparam string NO_NAME   = "()+-*/.$";
    localparam string AFTER_MIN = "a+-*/_()$.Z";

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    t_lex_in  i_in_word = '0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_lex_out o_out_word;
    logic     i_out_stall = 1'b0;

    s_expression_char_lexer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    // source words waiting for the driver, result words waiting for the dut
    t_lex_in  source_words [$];
    t_lex_out expected_tokens [$];

    int unsigned fail_count = 0;
    int unsigned results_seen = 0;

    // ------------------------------------------------------------------------
    // lexer tracked in the testbench
    // ------------------------------------------------------------------------
    t_lex_mode              sx_mode = M_START;
    logic [C_POS_WIDTH-1:0] pos_line = POS_ONE;
    logic [C_POS_WIDTH-1:0] pos_col = POS_ONE;
    // position of a '-' that waits for the next byte
    logic [C_POS_WIDTH-1:0] minus_line = '0;
    logic [C_POS_WIDTH-1:0] minus_col = '0;

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit alnum_ch(input logic [7:0] c);
        return digit_ch(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit name_ch(input logic [7:0] c);
        return alnum_ch(c) || c == C_CH_UNDER;
    endfunction

    function automatic bit sym_ch(input logic [7:0] c);
        return alnum_ch(c) || c == C_CH_MINUS || c == "+" || c == "*" || c == "/"
            || c == C_CH_UNDER;
    endfunction

    function automatic bit space_ch(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == C_CH_LF;
    endfunction

    task automatic emit(input logic [7:0] c, input logic [2:0] k, input logic st,
                        input logic iv, input logic [C_POS_WIDTH-1:0] ln,
                        input logic [C_POS_WIDTH-1:0] col, input logic [1:0] err);
        t_lex_out t;
        t.char_out     = c;
        t.kind         = k;
        t.starts_token = st;
        t.in_value     = iv;
        t.line_no      = ln;
        t.column_no    = col;
        t.error_code   = err;
        t.last_of_run  = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endtask

    // works out the result words of one accepted source word
    task automatic lex_source_word(input t_lex_in w);
        logic [7:0] c;
        bit         taken;
        int         queued_before;
        t_lex_out   last_tok;
        c = w.ch;
        taken = 1'b0;
        queued_before = expected_tokens.size();
        if (w.is_end) begin
            case (sx_mode)
                M_ERROR: ;
                M_NUM_POINT: emit(C_CH_NUL, K_ERROR, 1'b0, 1'b0, pos_line, pos_col,
                                  E_NO_FRAC);
                M_BIND_SIGIL: emit(C_CH_NUL, K_ERROR, 1'b0, 1'b0, pos_line, pos_col,
                                   E_EMPTY_BIND);
                M_MINUS: begin
                    emit(C_CH_MINUS, K_SYMBOL, 1'b1, 1'b1, minus_line, minus_col, E_NONE);
                    emit(C_CH_NUL, K_END, 1'b1, 1'b0, pos_line, pos_col, E_NONE);
                end
                default: emit(C_CH_NUL, K_END, 1'b1, 1'b0, pos_line, pos_col, E_NONE);
            endcase
            sx_mode  = M_START;
            pos_line = POS_ONE;
            pos_col  = POS_ONE;
        end else begin
            // a held '-' is settled by this byte
            if (sx_mode == M_MINUS) begin
                if (digit_ch(c)) begin
                    emit(C_CH_MINUS, K_NUMBER, 1'b1, 1'b1, minus_line, minus_col, E_NONE);
                    emit(c, K_NUMBER, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                    sx_mode = M_NUM_INT;
                    taken = 1'b1;
                end else begin
                    emit(C_CH_MINUS, K_SYMBOL, 1'b1, 1'b1, minus_line, minus_col, E_NONE);
                    sx_mode = M_SYMBOL;
                end
            end
            // continue the open token
            if (!taken) begin
                case (sx_mode)
                    M_ERROR: taken = 1'b1;
                    M_NUM_INT: begin
                        if (digit_ch(c) || c == C_CH_DOT) begin
                            emit(c, K_NUMBER, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            if (c == C_CH_DOT) sx_mode = M_NUM_POINT;
                            taken = 1'b1;
                        end
                    end
                    M_NUM_POINT: begin
                        if (digit_ch(c)) begin
                            emit(c, K_NUMBER, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            sx_mode = M_NUM_FRAC;
                        end else begin
                            emit(c, K_ERROR, 1'b0, 1'b0, pos_line, pos_col, E_NO_FRAC);
                            sx_mode = M_ERROR;
                        end
                        taken = 1'b1;
                    end
                    M_NUM_FRAC: begin
                        if (digit_ch(c)) begin
                            emit(c, K_NUMBER, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            taken = 1'b1;
                        end
                    end
                    M_SYMBOL: begin
                        if (sym_ch(c)) begin
                            emit(c, K_SYMBOL, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            taken = 1'b1;
                        end
                    end
                    M_BIND_SIGIL: begin
                        if (name_ch(c)) begin
                            emit(c, K_BINDING, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            sx_mode = M_BIND_NAME;
                        end else begin
                            emit(c, K_ERROR, 1'b0, 1'b0, pos_line, pos_col, E_EMPTY_BIND);
                            sx_mode = M_ERROR;
                        end
                        taken = 1'b1;
                    end
                    M_BIND_NAME: begin
                        if (name_ch(c)) begin
                            emit(c, K_BINDING, 1'b0, 1'b1, pos_line, pos_col, E_NONE);
                            taken = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            // byte starts something new
            if (!taken) begin
                if (space_ch(c)) begin
                    sx_mode = M_START;
                end else if (c == C_CH_LPAREN) begin
                    emit(c, K_LPAREN, 1'b1, 1'b1, pos_line, pos_col, E_NONE);
                    sx_mode = M_START;
                end else if (c == C_CH_RPAREN) begin
                    emit(c, K_RPAREN, 1'b1, 1'b1, pos_line, pos_col, E_NONE);
                    sx_mode = M_START;
                end else if (c == C_CH_DOLLAR) begin
                    emit(c, K_BINDING, 1'b1, 1'b0, pos_line, pos_col, E_NONE);
                    sx_mode = M_BIND_SIGIL;
                end else if (digit_ch(c)) begin
                    emit(c, K_NUMBER, 1'b1, 1'b1, pos_line, pos_col, E_NONE);
                    sx_mode = M_NUM_INT;
                end else if (c == C_CH_MINUS) begin
                    minus_line = pos_line;
                    minus_col  = pos_col;
                    sx_mode    = M_MINUS;
                end else if (sym_ch(c)) begin
                    emit(c, K_SYMBOL, 1'b1, 1'b1, pos_line, pos_col, E_NONE);
                    sx_mode = M_SYMBOL;
                end else begin
                    emit(c, K_ERROR, 1'b0, 1'b0, pos_line, pos_col, E_UNEXPECTED);
                    sx_mode = M_ERROR;
                end
            end
            // position moves on every byte, saturating
            if (c == C_CH_LF) begin
                if (pos_line != POS_MAX) pos_line = pos_line + POS_ONE;
                pos_col = POS_ONE;
            end else if (pos_col != POS_MAX) begin
                pos_col = pos_col + POS_ONE;
            end
        end
        // flag the final result word of this source word
        if (expected_tokens.size() > queued_before) begin
            last_tok = expected_tokens.pop_back();
            last_tok.last_of_run = 1'b1;
            expected_tokens.insert(expected_tokens.size(), last_tok);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        t_lex_in w;
        w.ch     = c;
        w.is_end = 1'b0;
        source_words.insert(source_words.size(), w);
    endtask

    // end of source; the byte lane carries junk that must be ignored
    task automatic push_end();
        t_lex_in w;
        w.ch     = 8'($urandom_range(0, 255));
        w.is_end = 1'b1;
        source_words.insert(source_words.size(), w);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endtask

    task automatic push_pick(input string s);
        push_byte(s[$urandom_range(0, s.len() - 1)]);
    endtask

    task automatic push_space();
        case ($urandom_range(0, 4))
            0, 1: push_byte(CH_SPACE);
            2: push_byte(CH_TAB);
            3: push_byte(CH_CR);
            default: push_byte(C_CH_LF);
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch on result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // source side driver: bursts of random length with random gaps between
    // ------------------------------------------------------------------------
    int unsigned tx_burst_left = 0;
    int unsigned tx_gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            // slot is free: either a gap cycle or the next word
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                i_in_valid <= 1'b0;
            end else if (source_words.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_word  <= source_words.pop_front();
                if (tx_burst_left > 0) tx_burst_left--;
                if (tx_burst_left == 0) begin
                    // now and then a long burst with no idling at all
                    tx_burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
                    tx_gap_left   = $urandom_range(0, 4);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side stall pattern, with two long hold-offs that back the
    // result queue up into the source channel
    // ------------------------------------------------------------------------
    int unsigned rx_cycles = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_pattern_left = 0;
    int unsigned rx_stall_pct = 0;

    always @(posedge i_clk) begin
        rx_cycles++;
        if (rx_cycles == HOLD_AT_1 || rx_cycles == HOLD_AT_2) rx_hold_left = HOLD_LEN;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            // pick a new stall density whenever the current pattern runs out
            if (rx_pattern_left == 0) begin
                rx_pattern_left = $urandom_range(4, 60);
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 30;
                    default: rx_stall_pct = 75;
                endcase
            end
            rx_pattern_left--;
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check accepted result words, then predict from accepted
    // source words (a result never shows up on the edge its word is taken)
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lex_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("result word with nothing pending",
                                    32'(o_out_word.char_out), 32'd0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_out_word.char_out !== want.char_out)
                        report_mismatch("char_out", 32'(o_out_word.char_out),
                                        32'(want.char_out));
                    if (o_out_word.kind !== want.kind)
                        report_mismatch("kind", 32'(o_out_word.kind), 32'(want.kind));
                    if (o_out_word.starts_token !== want.starts_token)
                        report_mismatch("starts_token", 32'(o_out_word.starts_token),
                                        32'(want.starts_token));
                    if (o_out_word.in_value !== want.in_value)
                        report_mismatch("in_value", 32'(o_out_word.in_value),
                                        32'(want.in_value));
                    if (o_out_word.line_no !== want.line_no)
                        report_mismatch("line_no", 32'(o_out_word.line_no),
                                        32'(want.line_no));
                    if (o_out_word.column_no !== want.column_no)
                        report_mismatch("column_no", 32'(o_out_word.column_no),
                                        32'(want.column_no));
                    if (o_out_word.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(o_out_word.error_code),
                                        32'(want.error_code));
                    if (o_out_word.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(o_out_word.last_of_run),
                                        32'(want.last_of_run));
                end
                results_seen++;
            end
            if (i_in_valid && !o_in_stall) lex_source_word(i_in_word);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    int unsigned cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("s_expression_char_lexer_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned random_base;
        int unsigned n_tok;
        int unsigned roll;

        // directed: signed fraction in parens, binding with underscore name,
        // minus turning into a symbol, empty binding then halt with junk and
        // a silent end, point at end, lone minus at end, nul as unexpected
        // character, sigil at end, no digit after point mid-stream
        push_text("(-7.5)$_ -a");
        push_byte(C_CH_LF);
        push_text("$)");
        push_byte(8'hFF);
        push_end();
        push_text("9.");
        push_end();
        push_byte(C_CH_MINUS);
        push_end();
        push_byte(8'h00);
        push_end();
        push_byte(C_CH_DOLLAR);
        push_end();
        push_text("1.z");
        push_end();
        push_byte(8'hFF);
        push_end();

        // random token programs, each closed by end of source
        random_base = source_words.size();
        while (source_words.size() < random_base + RANDOM_ITEMS) begin
            n_tok = $urandom_range(1, 20);
            for (int t = 0; t < n_tok; t++) begin
                roll = $urandom_range(0, 99);
                if (roll < 22) begin
                    // number, maybe negative, maybe with fraction
                    if ($urandom_range(0, 3) == 0) push_byte(C_CH_MINUS);
                    repeat ($urandom_range(1, 4)) push_pick(DIGITS);
                    if ($urandom_range(0, 2) == 0) begin
                        push_byte(C_CH_DOT);
                        repeat ($urandom_range(1, 3)) push_pick(DIGITS);
                    end
                end else if (roll < 42) begin
                    push_pick(SYM_HEAD);
                    repeat ($urandom_range(0, 4)) push_pick(SYM_BODY);
                end else if (roll < 58) begin
                    push_byte($urandom_range(0, 1) ? C_CH_LPAREN : C_CH_RPAREN);
                end else if (roll < 72) begin
                    push_byte(C_CH_DOLLAR);
                    repeat ($urandom_range(1, 4)) push_pick(NAME_BODY);
                end else if (roll < 80) begin
                    repeat ($urandom_range(1, 3)) push_space();
                end else if (roll < 90) begin
                    // broken or borderline sequences
                    case ($urandom_range(0, 4))
                        0: begin
                            push_pick(DIGITS);
                            push_byte(C_CH_DOT);
                            if ($urandom_range(0, 3) == 0) push_end();
                            else push_pick(NO_FRAC);
                        end
                        1: begin
                            push_byte(C_CH_DOLLAR);
                            if ($urandom_range(0, 3) == 0) push_end();
                            else push_pick(NO_NAME);
                        end
                        2: begin
                            push_byte(C_CH_MINUS);
                            push_pick(AFTER_MIN);
                        end
                        3: begin
                            push_byte(C_CH_MINUS);
                            push_space();
                        end
                        default: begin
                            push_byte(C_CH_MINUS);
                            push_end();
                        end
                    endcase
                end else if (roll < 95) begin
                    // any byte at all
                    push_byte(8'($urandom_range(0, 255)));
                end else begin
                    push_end();
                end
                // tokens mostly separated, sometimes abutting
                if ($urandom_range(0, 9) < 6) push_space();
            end
            push_end();
        end

        // hold reset at the start of the run, once
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the stimulus to drain and every result to arrive
        while (source_words.size() != 0 || i_in_valid || expected_tokens.size() != 0)
            @(posedge i_clk);
        // give stray result words time to appear
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("s_expression_char_lexer_top verification clean");
        end else begin
            $display("s_expression_char_lexer_top verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sexp_lex_pkg.sv
hw/rtl/s_expression_char_lexer_top.sv
tb/sv/tb_top.sv
